### src/hrw_pkg.sv
package hrw_pkg;

  localparam int unsigned KEY_W  = 63;
  localparam int unsigned LIM_W  = 13;
  localparam int unsigned LIM_RST = 4096;

  typedef struct packed {
    logic [62:0]        request_time;
    logic [62:0]        reply_time;
    logic [7:0]         op_kind;
    logic signed [31:0] requester;
    logic [31:0]        file_tag;
    logic [62:0]        file_offset;
    logic [30:0]        byte_count;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_EMIT, S_LAST, S_DN_CHK, S_DN_L, S_DN_R, S_UP_RD, S_UP_CMP
  } state_t;

  typedef enum logic [2:0] {
    RA_ZERO, RA_LAST, RA_CHILD, RA_RIGHT, RA_PARENT
  } raddr_t;

  typedef enum logic [1:0] {WS_CUR, WS_RD, WS_SEL} wsrc_t;

  typedef enum logic [2:0] {P_HOLD, P_ZERO, P_CNT, P_CHILD, P_PAR, P_SEL} pos_op_t;

  typedef enum logic [1:0] {C_HOLD, C_INC, C_DEC} cnt_op_t;

  typedef struct packed {
    logic    ld_in;
    logic    ld_cur_rd;
    logic    ld_child;
    logic    ld_lft;
    logic    rd_en;
    raddr_t  rd_addr;
    logic    wr_en;
    wsrc_t   wr_src;
    pos_op_t pos_op;
    cnt_op_t cnt_op;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic op;
    logic lt_lim;
    logic cnt_zero;
    logic pos_zero;
    logic child_ge;
    logic right_ok;
    logic rd_lt_cur;
    logic rd_le_cur;
    logic sel_lt_cur;
    logic out_free;
  } sts_t;

endpackage

### src/hrw_ram.sv
module hrw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/hrw_ctrl.sv
module hrw_ctrl
  import hrw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.in_op == OP_PUSH) begin
            state_nxt = sts.lt_lim ? S_UP_RD : S_EMIT;
          end else if (!sts.cnt_zero) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = (sts.op == OP_PUSH) ? S_DN_CHK : S_LAST;
        end
      end
      S_LAST:   state_nxt = sts.cnt_zero ? S_IDLE : S_DN_CHK;
      S_DN_CHK: state_nxt = sts.child_ge ? S_IDLE : S_DN_L;
      S_DN_L: begin
        if (sts.right_ok) begin
          state_nxt = S_DN_R;
        end else begin
          state_nxt = sts.rd_lt_cur ? S_DN_CHK : S_IDLE;
        end
      end
      S_DN_R:   state_nxt = sts.sel_lt_cur ? S_DN_CHK : S_IDLE;
      S_UP_RD:  state_nxt = sts.pos_zero ? S_IDLE : S_UP_CMP;
      S_UP_CMP: state_nxt = sts.rd_le_cur ? S_IDLE : S_UP_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{ld_in: 1'b0, ld_cur_rd: 1'b0, ld_child: 1'b0, ld_lft: 1'b0,
            rd_en: 1'b0, rd_addr: RA_ZERO, wr_en: 1'b0, wr_src: WS_CUR,
            pos_op: P_HOLD, cnt_op: C_HOLD, emit: 1'b0};
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          if (sts.in_op == OP_PUSH && sts.lt_lim) begin
            cmd.pos_op = P_CNT;
            cmd.cnt_op = C_INC;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = RA_ZERO;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.op == OP_PUSH) begin
            cmd.pos_op = P_ZERO;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = RA_LAST;
            cmd.cnt_op  = C_DEC;
          end
        end
      end
      S_LAST: begin
        cmd.ld_cur_rd = 1'b1;
        cmd.pos_op    = P_ZERO;
      end
      S_DN_CHK: begin
        cmd.ld_child = 1'b1;
        if (sts.child_ge) begin
          cmd.wr_en = 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = RA_CHILD;
        end
      end
      S_DN_L: begin
        if (sts.right_ok) begin
          cmd.ld_lft  = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = RA_RIGHT;
        end else if (sts.rd_lt_cur) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = WS_RD;
          cmd.pos_op = P_CHILD;
        end else begin
          cmd.wr_en = 1'b1;
        end
      end
      S_DN_R: begin
        cmd.wr_en = 1'b1;
        if (sts.sel_lt_cur) begin
          cmd.wr_src = WS_SEL;
          cmd.pos_op = P_SEL;
        end
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.wr_en = 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = RA_PARENT;
        end
      end
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (!sts.rd_le_cur) begin
          cmd.wr_src = WS_RD;
          cmd.pos_op = P_PAR;
        end
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

### src/hrw_dp.sv
module hrw_dp
  import hrw_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             in_opcode,
  input  rec_t             in_rec,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rec_t             out_rec,
  output logic             out_order_error,
  output logic             out_was_final
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > LIM_W) ? CW : LIM_W;
  localparam int unsigned XW = AW + 2;

  logic [LIM_W-1:0] lim_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW:0]      child_r;
  logic [KEY_W-1:0] last_r;
  logic             op_r;
  rec_t             cur_r, lft_r, out_rec_r;
  logic             out_valid_r, out_err_r, out_fin_r;

  rec_t             rdata, wdata, sel;
  logic [AW-1:0]    raddr, parent, sel_idx;
  logic [AW:0]      child_c;
  logic [LW-1:0]    eff_lim, lim_ext;
  logic             right_lt;

  hrw_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (pos_r),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign lim_ext = LW'(lim_r);
  always_comb begin
    if (lim_r == '0) begin
      eff_lim = LW'(1);
    end else if (lim_ext > LW'(DEPTH)) begin
      eff_lim = LW'(DEPTH);
    end else begin
      eff_lim = lim_ext;
    end
  end

  assign child_c  = {pos_r, 1'b1};
  assign parent   = AW'((pos_r - 1'b1) >> 1);
  assign right_lt = rdata.request_time < lft_r.request_time;
  assign sel      = right_lt ? rdata : lft_r;
  assign sel_idx  = right_lt ? (child_r[AW-1:0] + 1'b1) : child_r[AW-1:0];

  always_comb begin
    case (cmd.rd_addr)
      RA_ZERO:   raddr = '0;
      RA_LAST:   raddr = AW'(cnt_r - 1'b1);
      RA_CHILD:  raddr = child_c[AW-1:0];
      RA_RIGHT:  raddr = child_r[AW-1:0] + 1'b1;
      RA_PARENT: raddr = parent;
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_src)
      WS_CUR:  wdata = cur_r;
      WS_RD:   wdata = rdata;
      WS_SEL:  wdata = sel;
      default: wdata = cur_r;
    endcase
  end

  always_comb begin
    case (cmd.pos_op)
      P_HOLD:  pos_nxt = pos_r;
      P_ZERO:  pos_nxt = '0;
      P_CNT:   pos_nxt = AW'(cnt_r);
      P_CHILD: pos_nxt = child_r[AW-1:0];
      P_PAR:   pos_nxt = parent;
      P_SEL:   pos_nxt = sel_idx;
      default: pos_nxt = pos_r;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      C_HOLD:  cnt_nxt = cnt_r;
      C_INC:   cnt_nxt = cnt_r + 1'b1;
      C_DEC:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r       <= LIM_W'(LIM_RST);
      cnt_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        lim_r <= cfg_data;
      end
      cnt_r <= cnt_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        last_r      <= rdata.request_time;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.ld_in) begin
      cur_r <= in_rec;
      op_r  <= in_opcode;
    end else if (cmd.ld_cur_rd) begin
      cur_r <= rdata;
    end
    if (cmd.ld_child) begin
      child_r <= child_c;
    end
    if (cmd.ld_lft) begin
      lft_r <= rdata;
    end
    if (cmd.emit) begin
      out_rec_r <= rdata;
      out_err_r <= rdata.request_time < last_r;
      out_fin_r <= (op_r == OP_DRAIN) && (cnt_r == CW'(1));
    end
  end

  always_comb begin
    sts.in_op      = in_opcode;
    sts.op         = op_r;
    sts.lt_lim     = LW'(cnt_r) < eff_lim;
    sts.cnt_zero   = cnt_r == '0;
    sts.pos_zero   = pos_r == '0;
    sts.child_ge   = XW'(child_c) >= XW'(cnt_r);
    sts.right_ok   = (XW'(child_r) + 1'b1) < XW'(cnt_r);
    sts.rd_lt_cur  = rdata.request_time < cur_r.request_time;
    sts.rd_le_cur  = rdata.request_time <= cur_r.request_time;
    sts.sel_lt_cur = sel.request_time < cur_r.request_time;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_rec         = out_rec_r;
  assign out_order_error = out_err_r;
  assign out_was_final   = out_fin_r;

endmodule

### src/heap_reorder_window.sv
// Reorders trace records by request time through a min-heap window held in one
// single-port-read RAM of DEPTH records. A push below the window limit puts the
// record at the end and lifts it, one parent read per level, until it reaches
// the top or its parent is not later. A push into a full window fetches and
// emits the top and sinks the new record in its place; a drain fetches and
// emits the top, then fetches the last record and sinks it from the top, unless
// the heap is then empty; a drain of an empty heap emits nothing. The sift loop
// does one RAM read per child or parent, and an emission also waits while the
// previous result is stalled. One item is worked at a time; a finished result
// waits in the output register while the next item is taken.
module heap_reorder_window
  import hrw_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [62:0]        in_request_time,
  input  logic [62:0]        in_reply_time,
  input  logic [7:0]         in_op_kind,
  input  logic signed [31:0] in_requester,
  input  logic [31:0]        in_file_tag,
  input  logic [62:0]        in_file_offset,
  input  logic [30:0]        in_byte_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [62:0]        out_request_time,
  output logic [62:0]        out_reply_time,
  output logic [7:0]         out_op_kind,
  output logic signed [31:0] out_requester,
  output logic [31:0]        out_file_tag,
  output logic [62:0]        out_file_offset,
  output logic [30:0]        out_byte_count,
  output logic               out_order_error,
  output logic               out_was_final,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [12:0]        cfg_window_limit
);

  cmd_t cmd;
  sts_t sts;
  rec_t in_rec, out_rec;
  logic busy;

  assign in_rec = '{request_time: in_request_time, reply_time: in_reply_time,
                    op_kind: in_op_kind, requester: in_requester,
                    file_tag: in_file_tag, file_offset: in_file_offset,
                    byte_count: in_byte_count};

  hrw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  hrw_dp #(.DEPTH(DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_rec          (in_rec),
    .cfg_we          (cfg_valid),
    .cfg_data        (cfg_window_limit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rec         (out_rec),
    .out_order_error (out_order_error),
    .out_was_final   (out_was_final)
  );

  assign in_stall         = busy;
  assign cfg_ready        = 1'b1;
  assign out_request_time = out_rec.request_time;
  assign out_reply_time   = out_rec.reply_time;
  assign out_op_kind      = out_rec.op_kind;
  assign out_requester    = out_rec.requester;
  assign out_file_tag     = out_rec.file_tag;
  assign out_file_offset  = out_rec.file_offset;
  assign out_byte_count   = out_rec.byte_count;

endmodule

### src/hrw_chk.sv
module hrw_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_opcode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [62:0] out_request_time,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_request_time))
    else $error("stalled result changed");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_opcode |=> in_stall)
    else $error("push transfer did not occupy the block");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> cfg_ready)
    else $error("config port closed while idle");

endmodule

bind heap_reorder_window hrw_chk u_chk (.*);
